FILE: rtl/core/rmt_pkg.sv
// rename map table package: field widths, operation codes, item and result types
// shared by the table datapath and the top level; no dependencies
`timescale 1ns / 1ps

package rmt_pkg;

	// defaults for the top-level parameters
	localparam int NUM_REGS_DEF = 64;
	localparam int TAG_BITS_DEF = 16;

	// fixed field widths of the item and result ports
	localparam int FUNC_W = 2;
	localparam int REG_W  = 6;
	localparam int TAG_W  = 16;

	// operation codes
	localparam logic [FUNC_W-1:0] FUNC_RENAME   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_COMPLETE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_QUERY    = 2'd2;

	// one input item as held in the input register
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              src1_valid;
		logic [REG_W-1:0]  src1_reg;
		logic              src2_valid;
		logic [REG_W-1:0]  src2_reg;
		logic              dest_valid;
		logic [REG_W-1:0]  dest_reg;
		logic [TAG_W-1:0]  inst_tag;
		logic              src1_ready_in;
		logic [TAG_W-1:0]  src1_tag;
		logic              src2_ready_in;
		logic [TAG_W-1:0]  src2_tag;
	} item_t;

	// one result item
	typedef struct packed {
		logic             src1_ready;
		logic [TAG_W-1:0] src1_tag_out;
		logic             src2_ready;
		logic [TAG_W-1:0] src2_tag_out;
		logic             all_ready;
	} result_t;

endpackage

FILE: rtl/core/rmt_table.sv
// map table storage with source lookup, tag search and destination update
// depends on rmt_pkg for the item and result types and the operation codes
`timescale 1ns / 1ps

module rmt_table import rmt_pkg::*; #(
	parameter int NUM_REGS = NUM_REGS_DEF,
	parameter int TAG_BITS = TAG_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	output result_t res
);

	localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int EXT_W = (IDX_W > REG_W) ? IDX_W : REG_W;

	// per-register state: ready bits as a vector, producer tags as a row of registers
	logic [NUM_REGS-1:0] entry_ready_q;
	logic [TAG_BITS-1:0] entry_tag_q [NUM_REGS];

	function automatic logic in_range(input logic [REG_W-1:0] r);
		return (32'(r) < NUM_REGS);
	endfunction

	function automatic logic [IDX_W-1:0] to_idx(input logic [REG_W-1:0] r);
		logic [EXT_W-1:0] e;
		e = EXT_W'(r);
		return e[IDX_W-1:0];
	endfunction

	logic [IDX_W-1:0]    s1_idx, s2_idx, d_idx;
	logic                s1_ok, s2_ok, d_ok;
	logic [TAG_BITS-1:0] itag, q1_tag, q2_tag;
	logic [NUM_REGS-1:0] m1, m2, first1, first2;
	logic                hit1, hit2;

	assign s1_idx = to_idx(item.src1_reg);
	assign s2_idx = to_idx(item.src2_reg);
	assign d_idx  = to_idx(item.dest_reg);
	assign s1_ok  = in_range(item.src1_reg);
	assign s2_ok  = in_range(item.src2_reg);
	assign d_ok   = item.dest_valid && in_range(item.dest_reg);
	assign itag   = TAG_BITS'(item.inst_tag);
	assign q1_tag = TAG_BITS'(item.src1_tag);
	assign q2_tag = TAG_BITS'(item.src2_tag);

	// parallel tag compare against every entry
	always_comb begin
		for (int i = 0; i < NUM_REGS; i++) begin
			m1[i] = (entry_tag_q[i] == q1_tag);
			m2[i] = (entry_tag_q[i] == q2_tag);
		end
	end

	// lowest matching entry decides the ready bit
	assign first1 = m1 & (~m1 + NUM_REGS'(1));
	assign first2 = m2 & (~m2 + NUM_REGS'(1));
	assign hit1   = |(first1 & entry_ready_q);
	assign hit2   = |(first2 & entry_ready_q);

	// result of the operation, read before this item's update
	always_comb begin
		res = '0;
		case (item.func)
			FUNC_RENAME: begin
				if (!item.src1_valid) begin
					res.src1_ready   = 1'b1;
					res.src1_tag_out = '0;
				end else if (!s1_ok || entry_ready_q[s1_idx]) begin
					res.src1_ready   = 1'b1;
					res.src1_tag_out = TAG_W'(item.src1_reg);
				end else begin
					res.src1_ready   = 1'b0;
					res.src1_tag_out = TAG_W'(entry_tag_q[s1_idx]);
				end
				if (!item.src2_valid) begin
					res.src2_ready   = 1'b1;
					res.src2_tag_out = '0;
				end else if (!s2_ok || entry_ready_q[s2_idx]) begin
					res.src2_ready   = 1'b1;
					res.src2_tag_out = TAG_W'(item.src2_reg);
				end else begin
					res.src2_ready   = 1'b0;
					res.src2_tag_out = TAG_W'(entry_tag_q[s2_idx]);
				end
			end
			FUNC_QUERY: begin
				res.src1_ready   = item.src1_ready_in | hit1;
				res.src1_tag_out = item.src1_tag;
				res.src2_ready   = item.src2_ready_in | hit2;
				res.src2_tag_out = item.src2_tag;
			end
			default: begin
				res = '0;
			end
		endcase
		res.all_ready = res.src1_ready & res.src2_ready;
	end

	// destination update: rename claims the entry, complete wakes it on a tag match
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_ready_q <= '1;
			for (int i = 0; i < NUM_REGS; i++) begin
				entry_tag_q[i] <= '0;
			end
		end else if (fire && d_ok) begin
			case (item.func)
				FUNC_RENAME: begin
					entry_ready_q[d_idx] <= 1'b0;
					entry_tag_q[d_idx]   <= itag;
				end
				FUNC_COMPLETE: begin
					if (entry_tag_q[d_idx] == itag) begin
						entry_ready_q[d_idx] <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/rename_map_table_with_wakeup.sv
// path: an accepted item is held in the input register, then its result is held and offered in the result register
// throughput: one item per cycle while the result is not stalled; the table lookup, tag search and update fit one stage
// the next item sees the table as left by the previous one, since the update lands with its result
// reset: all entries ready with tag 0, both stages empty, in_ready high during and after reset
// depends on rmt_pkg and rmt_table
`timescale 1ns / 1ps

module rename_map_table_with_wakeup import rmt_pkg::*; #(
	parameter int NUM_REGS = NUM_REGS_DEF,
	parameter int TAG_BITS = TAG_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [FUNC_W-1:0] func,
	input  logic              src1_valid,
	input  logic [REG_W-1:0]  src1_reg,
	input  logic              src2_valid,
	input  logic [REG_W-1:0]  src2_reg,
	input  logic              dest_valid,
	input  logic [REG_W-1:0]  dest_reg,
	input  logic [TAG_W-1:0]  inst_tag,
	input  logic              src1_ready_in,
	input  logic [TAG_W-1:0]  src1_tag,
	input  logic              src2_ready_in,
	input  logic [TAG_W-1:0]  src2_tag,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              src1_ready,
	output logic [TAG_W-1:0]  src1_tag_out,
	output logic              src2_ready,
	output logic [TAG_W-1:0]  src2_tag_out,
	output logic              all_ready
);

	logic    s1_valid_q, out_valid_q;
	item_t   item_s1;
	result_t res, res_q;
	logic    advance, fire;

	// handshake: the stage moves on whenever the result slot is free or being drained
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !s1_valid_q || advance;
	assign fire     = s1_valid_q && advance;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				s1_valid_q <= in_valid;
			end
			if (advance) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.func          <= func;
			item_s1.src1_valid    <= src1_valid;
			item_s1.src1_reg      <= src1_reg;
			item_s1.src2_valid    <= src2_valid;
			item_s1.src2_reg      <= src2_reg;
			item_s1.dest_valid    <= dest_valid;
			item_s1.dest_reg      <= dest_reg;
			item_s1.inst_tag      <= inst_tag;
			item_s1.src1_ready_in <= src1_ready_in;
			item_s1.src1_tag      <= src1_tag;
			item_s1.src2_ready_in <= src2_ready_in;
			item_s1.src2_tag      <= src2_tag;
		end
	end

	// map table
	rmt_table #(
		.NUM_REGS (NUM_REGS),
		.TAG_BITS (TAG_BITS)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign src1_ready   = res_q.src1_ready;
	assign src1_tag_out = res_q.src1_tag_out;
	assign src2_ready   = res_q.src2_ready;
	assign src2_tag_out = res_q.src2_tag_out;
	assign all_ready    = res_q.all_ready;

endmodule

FILE: rtl/core/rmt_checker.sv
// port-level checks for the rename map table, attached to the top level by bind
// depends on rmt_pkg for field widths
`timescale 1ns / 1ps

module rmt_checker import rmt_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic             src1_ready,
	input logic [TAG_W-1:0] src1_tag_out,
	input logic             src2_ready,
	input logic [TAG_W-1:0] src2_tag_out,
	input logic             all_ready
);

	// a result stays offered until it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped before it was taken");

	// a stalled result keeps its fields
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(src1_ready) && $stable(src1_tag_out)
			&& $stable(src2_ready) && $stable(src2_tag_out) && $stable(all_ready))
		else $error("stalled result item changed");

	// issue flag agrees with the two source flags
	a_all_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> all_ready == (src1_ready && src2_ready))
		else $error("all_ready disagrees with the source ready bits");

	// an accepted item is followed by a result on offer once it has passed the input register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 out_valid)
		else $error("accepted item produced no result in time");

	// input is held off only by a stalled result
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input held off without a stalled result");

endmodule

bind rename_map_table_with_wakeup rmt_checker u_rmt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.src1_ready   (src1_ready),
	.src1_tag_out (src1_tag_out),
	.src2_ready   (src2_ready),
	.src2_tag_out (src2_tag_out),
	.all_ready    (all_ready)
);
